### hw/rtl/hsi_pkg.sv
`default_nettype none

package hsi_pkg;

   localparam int LIMB_BITS     = 32;
   localparam int COEF_BITS     = 16;
   localparam int COEF_FRAC     = 14;
   localparam int WEIGHT_BITS   = COEF_BITS + 1;
   localparam int KPROD_BITS    = 2 * WEIGHT_BITS - 1;
   localparam int TANGENT_SHIFT = 2 * COEF_FRAC + 1;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << COEF_FRAC;

   typedef enum logic {
      REG_TENSION = 1'b0,
      REG_BIAS    = 1'b1
   } hsi_reg_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } hsi_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/hermite_spline_interpolator_unit.sv
// Throughput: one request per clock unless a result waits for rsp_ready; the ten register
// stages (differences, tangent products, coefficients, three Horner steps of limb products
// then sum, saturation) all advance together and hold together while a result waits.
// Reset: synchronous, clears all valid bits and sets tension and bias to zero.
`default_nettype none

module hermite_spline_interpolator_unit #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]  req_sample_before,
   input  wire logic signed [SAMPLE_BITS-1:0]  req_sample_start,
   input  wire logic signed [SAMPLE_BITS-1:0]  req_sample_end,
   input  wire logic signed [SAMPLE_BITS-1:0]  req_sample_after,
   input  wire logic        [FRAC_BITS-1:0]    req_position,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_interpolated,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [hsi_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [hsi_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [hsi_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);
   import hsi_pkg::*;

   localparam int S   = SAMPLE_BITS;
   localparam int F   = FRAC_BITS;
   localparam int DW  = S + 1;
   localparam int MW  = S + KPROD_BITS + 1;
   localparam int CW  = MW + 1;
   localparam int R2W = CW + F + 1;
   localparam int R1W = R2W + F + 1;
   localparam int R0W = R1W + F + 1;
   localparam int SH  = 3 * F + TANGENT_SHIFT;
   localparam int QW  = R0W - SH;

   localparam logic signed [S-1:0] SAMPLE_MAX = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0] SAMPLE_MIN = {1'b1, {(S-1){1'b0}}};

   logic advance;
   logic csr_write;

   logic signed [COEF_BITS-1:0] tension_ff, bias_ff;

   logic signed [WEIGHT_BITS-1:0]   wa, wb, wt;
   logic signed [2*WEIGHT_BITS-1:0] ka_full, kb_full;
   logic signed [KPROD_BITS-1:0]    ka_ff, kb_ff;

   logic                   v1_ff;
   logic signed [DW-1:0]   d01_in, d12_in, d23_in;
   logic signed [DW-1:0]   d01_ff, d12_ff, d23_ff;
   logic signed [S-1:0]    y1_1ff;
   logic        [F-1:0]    p1_ff;

   logic                   v2_ff;
   logic signed [MW-1:0]   m0_in, m1_in, m0_ff, m1_ff;
   logic signed [DW-1:0]   d12_2ff;
   logic signed [S-1:0]    y1_2ff;
   logic        [F-1:0]    p2_ff;

   logic                   v3_ff;
   logic signed [CW-1:0]   d12_s, c3_in, c2_in, c3_ff, c2_ff;
   logic signed [MW-1:0]   c1_ff;
   logic signed [S-1:0]    y1_3ff;
   logic        [F-1:0]    p3_ff;

   logic        [F-1:0]    p_dly_ff  [4];
   logic signed [S-1:0]    y1_dly_ff [4];
   logic signed [MW-1:0]   c1_dly_ff [2];

   hsi_ctl_type            ctl_a, ctl_b, ctl_c;
   logic                   va, vb, vc;
   logic signed [R2W-1:0]  r2;
   logic signed [R1W-1:0]  r1;
   logic signed [R0W-1:0]  r0;

   logic signed [R0W-1:0]  shifted;
   logic signed [QW-1:0]   q;
   logic                   fits;
   logic signed [S-1:0]    interp_in, rsp_interpolated_ff;
   logic                   rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= '0;
         bias_ff    <= '0;
      end else if (csr_write) begin
         unique case (hsi_reg_type'(paddr[2]))
            REG_TENSION: tension_ff <= signed'(pwdata[COEF_BITS-1:0]);
            REG_BIAS:    bias_ff    <= signed'(pwdata[COEF_BITS-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (hsi_reg_type'(paddr[2]))
         REG_TENSION: prdata = CSR_DATA_BITS'(tension_ff);
         REG_BIAS:    prdata = CSR_DATA_BITS'(bias_ff);
         default:     prdata = '0;
      endcase
   end

   assign wa      = WEIGHT_ONE + WEIGHT_BITS'(bias_ff);
   assign wb      = WEIGHT_ONE - WEIGHT_BITS'(bias_ff);
   assign wt      = WEIGHT_ONE - WEIGHT_BITS'(tension_ff);
   assign ka_full = wt * wa;
   assign kb_full = wt * wb;

   always_ff @(posedge clock) begin
      ka_ff <= signed'(ka_full[KPROD_BITS-1:0]);
      kb_ff <= signed'(kb_full[KPROD_BITS-1:0]);
   end

   assign d01_in = DW'(req_sample_start) - DW'(req_sample_before);
   assign d12_in = DW'(req_sample_end)   - DW'(req_sample_start);
   assign d23_in = DW'(req_sample_after) - DW'(req_sample_end);

   assign m0_in = ka_ff * d01_ff + kb_ff * d12_ff;
   assign m1_in = ka_ff * d12_ff + kb_ff * d23_ff;

   assign d12_s = CW'(d12_2ff) <<< TANGENT_SHIFT;
   assign c3_in = m0_ff + m1_ff - (d12_s <<< 1);
   assign c2_in = d12_s + (d12_s <<< 1) - (m0_ff <<< 1) - m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= vc;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d01_ff  <= d01_in;
         d12_ff  <= d12_in;
         d23_ff  <= d23_in;
         y1_1ff  <= req_sample_start;
         p1_ff   <= req_position;
         m0_ff   <= m0_in;
         m1_ff   <= m1_in;
         d12_2ff <= d12_ff;
         y1_2ff  <= y1_1ff;
         p2_ff   <= p1_ff;
         c3_ff   <= c3_in;
         c2_ff   <= c2_in;
         c1_ff   <= m0_ff;
         y1_3ff  <= y1_2ff;
         p3_ff   <= p2_ff;
         p_dly_ff[0]  <= p3_ff;
         y1_dly_ff[0] <= y1_3ff;
         c1_dly_ff[0] <= c1_ff;
         c1_dly_ff[1] <= c1_dly_ff[0];
         for (int k = 1; k < 4; k++) begin
            p_dly_ff[k]  <= p_dly_ff[k-1];
            y1_dly_ff[k] <= y1_dly_ff[k-1];
         end
         rsp_interpolated_ff <= interp_in;
      end
   end

   assign ctl_a.advance = advance;
   assign ctl_a.valid   = v3_ff;
   assign ctl_b.advance = advance;
   assign ctl_b.valid   = va;
   assign ctl_c.advance = advance;
   assign ctl_c.valid   = vb;

   hsi_horner_step #(
      .R_W(CW), .F_W(F), .A_W(CW), .SHIFT(F)
   ) u_step_a (
      .clock(clock), .reset(reset), .ctl_in(ctl_a),
      .r(c3_ff), .p(p3_ff), .addend(c2_ff),
      .out_valid(va), .r_next(r2)
   );

   hsi_horner_step #(
      .R_W(R2W), .F_W(F), .A_W(MW), .SHIFT(2 * F)
   ) u_step_b (
      .clock(clock), .reset(reset), .ctl_in(ctl_b),
      .r(r2), .p(p_dly_ff[1]), .addend(c1_dly_ff[1]),
      .out_valid(vb), .r_next(r1)
   );

   hsi_horner_step #(
      .R_W(R1W), .F_W(F), .A_W(S), .SHIFT(SH)
   ) u_step_c (
      .clock(clock), .reset(reset), .ctl_in(ctl_c),
      .r(r1), .p(p_dly_ff[3]), .addend(y1_dly_ff[3]),
      .out_valid(vc), .r_next(r0)
   );

   assign shifted = r0 >>> SH;
   assign q       = signed'(shifted[QW-1:0]);
   assign fits    = (&q[QW-1:S-1]) || !(|q[QW-1:S-1]);

   always_comb begin
      if (fits) begin
         interp_in = signed'(q[S-1:0]);
      end else if (q[QW-1]) begin
         interp_in = SAMPLE_MIN;
      end else begin
         interp_in = SAMPLE_MAX;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = rsp_interpolated_ff;

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output register");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted request did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v1_ff) && $stable(v2_ff) && $stable(v3_ff)
                   && $stable(va) && $stable(vb) && $stable(vc))
      else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

### hw/rtl/hsi_horner_step.sv
`default_nettype none

module hsi_horner_step #(
   parameter int R_W   = 64,
   parameter int F_W   = 16,
   parameter int A_W   = 32,
   parameter int SHIFT = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hsi_pkg::hsi_ctl_type     ctl_in,
   input  wire logic signed [R_W-1:0]    r,
   input  wire logic        [F_W-1:0]    p,
   input  wire logic signed [A_W-1:0]    addend,
   output logic                          out_valid,
   output logic signed [R_W+F_W:0]       r_next
);
   import hsi_pkg::*;

   localparam int O_W   = R_W + F_W + 1;
   localparam int N     = (R_W + LIMB_BITS - 1) / LIMB_BITS;
   localparam int PAD_W = N * LIMB_BITS;
   localparam int PW    = PAD_W + F_W + 1;

   logic signed [PAD_W-1:0]         r_pad;
   logic        [LIMB_BITS+F_W-1:0] lo_part;
   logic signed [LIMB_BITS+F_W:0]   hi_part;
   logic signed [PW-1:0]            term;
   logic signed [PW-1:0]            even_acc;
   logic signed [PW-1:0]            odd_acc;

   logic signed [O_W-1:0] even_in, odd_in, even_ff, odd_ff;
   logic signed [A_W-1:0] addend_ff;
   logic                  valid_m_ff;
   logic signed [O_W-1:0] r_next_in, r_next_ff;
   logic                  valid_a_ff;

   assign r_pad = PAD_W'(r);

   always_comb begin
      even_acc = '0;
      odd_acc  = '0;
      lo_part  = '0;
      hi_part  = '0;
      term     = '0;
      for (int i = 0; i < N; i++) begin
         if (i == N - 1) begin
            hi_part = signed'(r_pad[i*LIMB_BITS +: LIMB_BITS]) * signed'({1'b0, p});
            term    = PW'(hi_part) <<< (i * LIMB_BITS);
         end else begin
            lo_part = r_pad[i*LIMB_BITS +: LIMB_BITS] * p;
            term    = signed'(PW'(lo_part)) <<< (i * LIMB_BITS);
         end
         if (i[0] == 1'b0) begin
            even_acc = even_acc | term;
         end else begin
            odd_acc = odd_acc | term;
         end
      end
   end

   assign even_in   = signed'(even_acc[O_W-1:0]);
   assign odd_in    = signed'(odd_acc[O_W-1:0]);
   assign r_next_in = even_ff + odd_ff + (O_W'(addend_ff) <<< SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_m_ff <= 1'b0;
         valid_a_ff <= 1'b0;
      end else if (ctl_in.advance) begin
         valid_m_ff <= ctl_in.valid;
         valid_a_ff <= valid_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         even_ff   <= even_in;
         odd_ff    <= odd_in;
         addend_ff <= addend;
         r_next_ff <= r_next_in;
      end
   end

   assign out_valid = valid_a_ff;
   assign r_next    = r_next_ff;

endmodule

`default_nettype wire
